@@ design/fca_pkg.sv @@
// fca_pkg: constants, tag layout and codes for the first-fit coalescing allocator.
// Used by the channel interfaces, the allocator core and its testbench.
// No dependencies.
package fca_pkg;

    // Pool geometry
    localparam int POOL_BYTES = 2048;
    localparam int TAG_BYTES  = 9;
    localparam int MIN_BLOCK  = 25;

    // Widths
    localparam int ADDR_W     = $clog2(POOL_BYTES);   // offset into the pool
    localparam int SIZE_W     = ADDR_W + 1;           // block size, holds POOL_BYTES
    localparam int POS_W      = ADDR_W + 1;           // walk position, holds pool end
    localparam int REQ_SIZE_W = 12;                   // req_size field
    localparam int NEED_W     = REQ_SIZE_W + 1;       // req_size plus both tags

    // One boundary tag: free flag and block size (tags included)
    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } tag_t;

    localparam int TAG_W = $bits(tag_t);

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Status codes
    localparam logic ST_DONE  = 1'b0;
    localparam logic ST_NOFIT = 1'b1;

endpackage

@@ design/fca_req_if.sv @@
// fca_req_if: request channel (valid/ready) of the allocator.
// Depends on fca_pkg for field widths.
interface fca_req_if;
    import fca_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [REQ_SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0]     block_addr;

    modport source (output valid, output req_type, output req_size, output block_addr,
                     input ready);
    modport sink   (input valid, input req_type, input req_size, input block_addr,
                     output ready);
endinterface

@@ design/fca_rsp_if.sv @@
// fca_rsp_if: result channel (valid/ready) of the allocator.
// Depends on fca_pkg for field widths.
interface fca_rsp_if;
    import fca_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic [ADDR_W-1:0] payload_addr;

    modport source (output valid, output status, output payload_addr, input ready);
    modport sink   (input valid, input status, input payload_addr, output ready);
endinterface

@@ design/fca_ram.sv @@
// fca_ram: generic simple dual-port RAM, one write and one read port,
// registered read data. No dependencies.
module fca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

@@ design/first_fit_coalescing_allocator_core.sv @@
// first_fit_coalescing_allocator_core: first-fit pool allocator, boundary-tag merge.
// Depends on fca_pkg, fca_req_if, fca_rsp_if and fca_ram (tag store).
//
//   channel | modport | moves                               | transaction when
//   --------+---------+-------------------------------------+-------------------
//   req     | sink    | req_type, req_size, block_addr      | valid && ready
//   rsp     | source  | status, payload_addr                | valid && ready
//
// One request at a time. The sequencer walks block heads from offset 0 through
// the tag RAM; each block visited passes S_READ (read issue), then S_CHECK
// (check), since the RAM read data is registered. No clearing pass after reset:
// only offset 0 is read before being written, and a valid flag supplies its
// reset tag. The result waits in an output register, so a new request is taken
// while an earlier result is stalled.
module first_fit_coalescing_allocator_core (
    input  logic  clk,
    input  logic  rst_n,
    fca_req_if.sink   req,
    fca_rsp_if.source rsp
);
    import fca_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_READ   = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_SPLIT  = 8'b0000_1000,
        S_NREAD  = 8'b0001_0000,
        S_NCHECK = 8'b0010_0000,
        S_MERGE  = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    // Control state
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   zero_valid_reg, zero_valid_next;

    // Working registers
    logic              is_free_reg, is_free_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [ADDR_W-1:0] target_reg, target_next;
    logic [ADDR_W-1:0] prev_pos_reg, prev_pos_next;
    logic [SIZE_W-1:0] prev_size_reg, prev_size_next;
    logic              prev_free_reg, prev_free_next;
    logic [SIZE_W-1:0] cur_size_reg, cur_size_next;
    logic [ADDR_W-1:0] nxt_pos_reg, nxt_pos_next;
    logic [SIZE_W-1:0] nxt_add_reg, nxt_add_next;
    logic [ADDR_W-1:0] split_pos_reg, split_pos_next;
    logic [SIZE_W-1:0] split_size_reg, split_size_next;
    logic              res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              out_status_reg, out_status_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;

    // Tag RAM ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    tag_t              wr_tag;
    logic [ADDR_W-1:0] rd_addr;
    logic [TAG_W-1:0]  rd_data;

    // Datapath helpers
    tag_t              cur_tag;
    tag_t              raw_tag;
    logic [POS_W-1:0]  pos_step;
    logic [SIZE_W-1:0] remain;
    logic [SIZE_W-1:0] merge_base;

    fca_ram #(
        .WIDTH (TAG_W),
        .DEPTH (POOL_BYTES)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_tag),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Read address: walk position, or the block after the one being freed
    assign rd_addr = (state_reg == S_NREAD) ? nxt_pos_reg : pos_reg[ADDR_W-1:0];

    // Offset 0 reads as the reset tag until it is first written
    assign raw_tag = tag_t'(rd_data);
    always_comb
    begin
        if ((pos_reg == '0) && !zero_valid_reg)
        begin
            cur_tag.free = 1'b1;
            cur_tag.size = SIZE_W'(POOL_BYTES);
        end
        else
        begin
            cur_tag = raw_tag;
        end
    end

    assign pos_step   = pos_reg + POS_W'(cur_tag.size);
    assign remain     = cur_tag.size - need_reg[SIZE_W-1:0];
    assign merge_base = cur_size_reg + nxt_add_reg;

    // Handshake outputs
    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.payload_addr = out_addr_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        is_free_next    = is_free_reg;
        pos_next        = pos_reg;
        need_next       = need_reg;
        target_next     = target_reg;
        prev_pos_next   = prev_pos_reg;
        prev_size_next  = prev_size_reg;
        prev_free_next  = prev_free_reg;
        cur_size_next   = cur_size_reg;
        nxt_pos_next    = nxt_pos_reg;
        nxt_add_next    = nxt_add_reg;
        split_pos_next  = split_pos_reg;
        split_size_next = split_size_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg[ADDR_W-1:0];
        wr_tag          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    is_free_next    = (req.req_type == REQ_FREE);
                    need_next       = NEED_W'(req.req_size) + NEED_W'(2 * TAG_BYTES);
                    target_next     = req.block_addr - ADDR_W'(TAG_BYTES);
                    pos_next        = '0;
                    prev_free_next  = 1'b0;
                    res_status_next = ST_DONE;
                    res_addr_next   = '0;
                    // Free below the first payload offset names no block
                    if ((req.req_type == REQ_FREE) &&
                        (req.block_addr < ADDR_W'(TAG_BYTES)))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (!is_free_reg)
                begin
                    // Allocate: first free block that is large enough
                    if (cur_tag.size == '0)
                    begin
                        res_status_next = ST_NOFIT;
                        state_next      = S_FINISH;
                    end
                    else if (cur_tag.free && ({1'b0, cur_tag.size} >= need_reg))
                    begin
                        wr_en         = 1'b1;
                        res_addr_next = pos_reg[ADDR_W-1:0] + ADDR_W'(TAG_BYTES);
                        if (remain >= SIZE_W'(MIN_BLOCK))
                        begin
                            wr_tag.free     = 1'b0;
                            wr_tag.size     = need_reg[SIZE_W-1:0];
                            split_pos_next  = pos_reg[ADDR_W-1:0] + need_reg[ADDR_W-1:0];
                            split_size_next = remain;
                            state_next      = S_SPLIT;
                        end
                        else
                        begin
                            wr_tag.free = 1'b0;
                            wr_tag.size = cur_tag.size;
                            state_next  = S_FINISH;
                        end
                    end
                    else if (pos_step >= POS_W'(POOL_BYTES))
                    begin
                        res_status_next = ST_NOFIT;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        pos_next   = pos_step;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    // Free: walk to the target block, keeping the previous head
                    if ((cur_tag.size == '0) || (pos_reg > {1'b0, target_reg}))
                    begin
                        state_next = S_FINISH;
                    end
                    else if (pos_reg == {1'b0, target_reg})
                    begin
                        if (cur_tag.free)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cur_size_next = cur_tag.size;
                            nxt_add_next  = '0;
                            if (pos_step >= POS_W'(POOL_BYTES))
                            begin
                                state_next = S_MERGE;
                            end
                            else
                            begin
                                nxt_pos_next = pos_step[ADDR_W-1:0];
                                state_next   = S_NREAD;
                            end
                        end
                    end
                    else
                    begin
                        prev_pos_next  = pos_reg[ADDR_W-1:0];
                        prev_size_next = cur_tag.size;
                        prev_free_next = cur_tag.free;
                        if (pos_step >= POS_W'(POOL_BYTES))
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            pos_next   = pos_step;
                            state_next = S_READ;
                        end
                    end
                end
            end

            // Remainder head of a split block
            S_SPLIT:
            begin
                wr_en       = 1'b1;
                wr_addr     = split_pos_reg;
                wr_tag.free = 1'b1;
                wr_tag.size = split_size_reg;
                state_next  = S_FINISH;
            end

            S_NREAD:
            begin
                state_next = S_NCHECK;
            end

            // Following block joins when it is free
            S_NCHECK:
            begin
                nxt_add_next = raw_tag.free ? raw_tag.size : '0;
                state_next   = S_MERGE;
            end

            // Write the merged head: at the previous block when it is free
            S_MERGE:
            begin
                wr_en       = 1'b1;
                wr_tag.free = 1'b1;
                if (prev_free_reg)
                begin
                    wr_addr     = prev_pos_reg;
                    wr_tag.size = prev_size_reg + merge_base;
                end
                else
                begin
                    wr_addr     = pos_reg[ADDR_W-1:0];
                    wr_tag.size = merge_base;
                end
                state_next = S_FINISH;
            end

            // Hand the result to the output register once it is free
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Offset 0 holds real data after its first write
    assign zero_valid_next = zero_valid_reg || (wr_en && (wr_addr == '0));

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            zero_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            zero_valid_reg <= zero_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        is_free_reg    <= is_free_next;
        pos_reg        <= pos_next;
        need_reg       <= need_next;
        target_reg     <= target_next;
        prev_pos_reg   <= prev_pos_next;
        prev_size_reg  <= prev_size_next;
        prev_free_reg  <= prev_free_next;
        cur_size_reg   <= cur_size_next;
        nxt_pos_reg    <= nxt_pos_next;
        nxt_add_reg    <= nxt_add_next;
        split_pos_reg  <= split_pos_next;
        split_size_reg <= split_size_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end
endmodule

@@ tb/tb_first_fit_coalescing_allocator_core.sv @@
// Testbench for first_fit_coalescing_allocator_core: directed and random alloc/free traffic.
// A built-in pool model predicts every result; depends on fca_pkg, fca_req_if, fca_rsp_if.
`timescale 1ns / 1ps

module tb_first_fit_coalescing_allocator_core;
    import fca_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_CYCLES = 600;

    typedef struct packed {
        logic                  req_type;
        logic [REQ_SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0]     block_addr;
    } pool_req_t;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] payload_addr;
    } pool_rsp_t;

    logic clk;
    logic rst_n;

    fca_req_if req_ch ();
    fca_rsp_if rsp_ch ();

    first_fit_coalescing_allocator_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Pool model: size and free flag per offset, meaningful only at block starts
    int        pool_size_tag [POOL_BYTES];
    bit        pool_free_tag [POOL_BYTES];
    bit        freed_now;

    pool_req_t         pending_q[$];
    pool_rsp_t         expected_q[$];
    logic [ADDR_W-1:0] live_addrs[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  req_taken;
    int  error_count;
    int  n_requests;
    int  n_results;
    int  n_grants;
    int  n_nofit;
    int  n_released;
    int  n_ignored;
    int  n_merges;

    // Merge every pair of adjacent free blocks, walking from offset 0
    function automatic void coalesce_pool();
        int pos;
        int nxt;
        pos = 0;
        while (pos < POOL_BYTES && pool_size_tag[pos] != 0) begin
            nxt = pos + pool_size_tag[pos];
            if (nxt >= POOL_BYTES)
                break;
            if (pool_free_tag[pos] && pool_free_tag[nxt] && pool_size_tag[nxt] != 0) begin
                pool_size_tag[pos] = pool_size_tag[pos] + pool_size_tag[nxt];
                pool_size_tag[nxt] = 0;
                pool_free_tag[nxt] = 1'b0;
                n_merges++;
            end
            else begin
                pos = nxt;
            end
        end
    endfunction

    // Apply one request to the pool model and return the result it should produce
    function automatic pool_rsp_t serve_request(input pool_req_t r);
        pool_rsp_t res;
        int        pos;
        int        need;
        int        remainder;
        int        target;
        bit        hit;
        res.status       = ST_DONE;
        res.payload_addr = '0;
        pos              = 0;
        hit              = 1'b0;
        freed_now        = 1'b0;
        if (r.req_type == REQ_ALLOC) begin
            need = int'(r.req_size) + 2 * TAG_BYTES;
            while (!hit && pos < POOL_BYTES && pool_size_tag[pos] != 0) begin
                if (pool_free_tag[pos] && pool_size_tag[pos] >= need) begin
                    hit       = 1'b1;
                    remainder = pool_size_tag[pos] - need;
                    // split only when the leftover can stand as a block
                    if (remainder >= MIN_BLOCK) begin
                        if (pos + need < POOL_BYTES) begin
                            pool_size_tag[pos + need] = remainder;
                            pool_free_tag[pos + need] = 1'b1;
                        end
                        pool_size_tag[pos] = need;
                    end
                    pool_free_tag[pos] = 1'b0;
                    res.payload_addr   = ADDR_W'(pos + TAG_BYTES);
                end
                else begin
                    pos = pos + pool_size_tag[pos];
                end
            end
            if (!hit)
                res.status = ST_NOFIT;
        end
        else if (int'(r.block_addr) >= TAG_BYTES) begin
            target = int'(r.block_addr) - TAG_BYTES;
            while (!hit && pos < POOL_BYTES && pool_size_tag[pos] != 0 && pos <= target) begin
                if (pos == target) begin
                    hit = 1'b1;
                    if (!pool_free_tag[pos]) begin
                        pool_free_tag[pos] = 1'b1;
                        freed_now          = 1'b1;
                        coalesce_pool();
                    end
                end
                else begin
                    pos = pos + pool_size_tag[pos];
                end
            end
        end
        return res;
    endfunction

    // Hand one request to the driver, keeping the backlog short
    task automatic queue_request(input logic kind, input int size, input int addr);
        pool_req_t r;
        r.req_type   = kind;
        r.req_size   = REQ_SIZE_W'(size);
        r.block_addr = ADDR_W'(addr);
        while (pending_q.size() >= 2)
            @(negedge clk);
        pending_q.insert(pending_q.size(), r);
    endtask

    // Clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Reset, input defaults and pool model reset
    initial begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_ALLOC;
        req_ch.req_size  = '0;
        req_ch.block_addr = '0;
        rsp_ch.ready     = 1'b0;
        for (int i = 0; i < POOL_BYTES; i++) begin
            pool_size_tag[i] = 0;
            pool_free_tag[i] = 1'b0;
        end
        pool_size_tag[0] = POOL_BYTES;
        pool_free_tag[0] = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Request driver: inputs move on the falling edge
    always @(negedge clk) begin
        pool_req_t r;
        if (rst_n && (!req_ch.valid || req_taken)) begin
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                r = pending_q.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.req_type   <= r.req_type;
                req_ch.req_size   <= r.req_size;
                req_ch.block_addr <= r.block_addr;
            end
            else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result-side backpressure
    always @(negedge clk) begin
        if (rst_n)
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Request transactions feed the pool model
    always @(posedge clk) begin
        pool_req_t r;
        pool_rsp_t res;
        req_taken <= req_ch.valid && req_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready) begin
            r.req_type   = req_ch.req_type;
            r.req_size   = req_ch.req_size;
            r.block_addr = req_ch.block_addr;
            res          = serve_request(r);
            expected_q.insert(expected_q.size(), res);
            n_requests++;
            if (r.req_type == REQ_ALLOC) begin
                if (res.status == ST_NOFIT) begin
                    n_nofit++;
                end
                else begin
                    n_grants++;
                    live_addrs.insert(live_addrs.size(), res.payload_addr);
                end
            end
            else if (freed_now) begin
                n_released++;
                for (int i = 0; i < live_addrs.size(); i++) begin
                    if (live_addrs[i] == r.block_addr) begin
                        live_addrs.delete(i);
                        break;
                    end
                end
            end
            else begin
                n_ignored++;
            end
        end
    end

    // Result monitor: compare each transaction with the oldest expectation
    always @(posedge clk) begin
        pool_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                $error("unexpected result: status %0d, payload_addr %0d",
                       rsp_ch.status, rsp_ch.payload_addr);
                error_count++;
            end
            else begin
                want = expected_q.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.payload_addr !== want.payload_addr) begin
                    $error("payload_addr mismatch: expected %0d, actual %0d",
                           want.payload_addr, rsp_ch.payload_addr);
                    error_count++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        int pick;
        int size;
        int idx;
        int alloc_pct;
        error_count   = 0;
        n_requests    = 0;
        n_results     = 0;
        n_grants      = 0;
        n_nofit       = 0;
        n_released    = 0;
        n_ignored     = 0;
        n_merges      = 0;
        send_idle_pct = 28;
        recv_idle_pct = 70;
        @(posedge rst_n);

        // Directed: no fit, exact whole-pool grant, bad and repeated frees,
        // small-remainder grants, splits and merges across neighbors
        queue_request(REQ_ALLOC, 2048, 0);
        queue_request(REQ_ALLOC, 4095, 0);
        queue_request(REQ_ALLOC, 2030, 0);
        queue_request(REQ_ALLOC, 0, 0);
        queue_request(REQ_FREE, 0, 9);
        queue_request(REQ_FREE, 0, 9);
        queue_request(REQ_FREE, 4095, 0);
        queue_request(REQ_FREE, 0, 8);
        queue_request(REQ_FREE, 0, 2047);
        queue_request(REQ_ALLOC, 0, 2047);
        queue_request(REQ_ALLOC, 100, 0);
        queue_request(REQ_ALLOC, 2000, 0);
        queue_request(REQ_ALLOC, 1880, 0);
        queue_request(REQ_FREE, 0, 36);
        queue_request(REQ_ALLOC, 50, 0);
        queue_request(REQ_FREE, 0, 9);
        queue_request(REQ_FREE, 0, 27);
        queue_request(REQ_FREE, 0, 145);
        queue_request(REQ_FREE, 0, 1024);
        queue_request(REQ_ALLOC, 2029, 0);
        queue_request(REQ_FREE, 0, 9);
        queue_request(REQ_ALLOC, 1006, 0);
        queue_request(REQ_ALLOC, 1005, 0);
        queue_request(REQ_FREE, 0, 1033);
        queue_request(REQ_FREE, 0, 9);

        // Random: mostly allocs and frees of live blocks, some noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 70;
                recv_idle_pct = 28;
            end
            else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick      = $urandom_range(0, 99);
            alloc_pct = (live_addrs.size() < 12) ? 65 : 40;
            if (pick < 6) begin
                // free at an arbitrary offset
                queue_request(REQ_FREE, $urandom_range(0, 4095), $urandom_range(0, 2047));
            end
            else if (pick < 10) begin
                // any size, mostly no fit
                queue_request(REQ_ALLOC, $urandom_range(0, 4095), $urandom_range(0, 2047));
            end
            else if (live_addrs.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    size = $urandom_range(0, 96);
                else if (pick < 95)
                    size = $urandom_range(97, 600);
                else
                    size = $urandom_range(601, 2030);
                queue_request(REQ_ALLOC, size, $urandom_range(0, 2047));
            end
            else begin
                idx  = $urandom_range(0, live_addrs.size() - 1);
                size = int'(live_addrs[idx]);
                // now and then miss the block start by a byte
                if ($urandom_range(0, 99) < 5)
                    size = ($urandom_range(0, 1) != 0) ? size + 1 : size - 1;
                queue_request(REQ_FREE, $urandom_range(0, 4095), size & (POOL_BYTES - 1));
            end
        end

        // Drain
        while (pending_q.size() != 0 || req_ch.valid)
            @(negedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            error_count++;
        end

        $display("Ran %0d requests, %0d results checked: %0d grants, %0d no-fit allocs,",
                 n_requests, n_results, n_grants, n_nofit);
        $display("%0d blocks released, %0d frees ignored, %0d neighbor merges.",
                 n_released, n_ignored, n_merges);
        if (error_count == 0)
            $display("first_fit_coalescing_allocator_core test passed");
        else
            $display("first_fit_coalescing_allocator_core test failed");
        $finish;
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("first_fit_coalescing_allocator_core test failed");
        $finish;
    end

endmodule
